/* rtl/core/tcpc_pkg.sv */
// ----------------------------------------------------------------------------
// tcpc_pkg
// Shared types, register codes and palette helpers for the text cell pixel
// compositor.
// ----------------------------------------------------------------------------
package tcpc_pkg;

  localparam int PALETTE_SIZE = 16;
  localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

  localparam int CW_W      = 6;   // cell_width register
  localparam int CH_W      = 7;   // cell_height register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH  = 2'd0,
    REG_CELL_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic right_border;
    logic left_border;
    logic top_border;
    logic underline;
    logic line_draw;
    logic inverse;
  } style_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [15:0] pal565(input logic [PAL_IDX_W-1:0] idx);
    logic [15:0] c;
    case (idx)
      4'd0:    c = 16'h0000;
      4'd1:    c = 16'h0010;
      4'd2:    c = 16'h0400;
      4'd3:    c = 16'h0410;
      4'd4:    c = 16'h8000;
      4'd5:    c = 16'h8010;
      4'd6:    c = 16'h8400;
      4'd7:    c = 16'h8410;
      4'd8:    c = 16'h4208;
      4'd9:    c = 16'h001F;
      4'd10:   c = 16'h07E0;
      4'd11:   c = 16'h07FF;
      4'd12:   c = 16'hF800;
      4'd13:   c = 16'hF81F;
      4'd14:   c = 16'hFFE0;
      4'd15:   c = 16'hFFFF;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Widen RGB565 to RGB888 by replicating the top bits into the low bits.
  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t p;
    p.red   = {c[15:11], c[15:13]};
    p.green = {c[10:5],  c[10:9]};
    p.blue  = {c[4:0],   c[4:2]};
    return p;
  endfunction

endpackage

/* rtl/core/text_cell_pixel_compositor_unit.sv */
// ----------------------------------------------------------------------------
// text_cell_pixel_compositor_unit
// Three-stage pixel pipeline: palette and coverage, blend products, and the
// divide by 255 into the output register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | character, indices, style, links,
//          |           |                       | column, row, glyph alpha
//  out_    | output    | out_valid / out_ready | red, green, blue
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per clock is accepted unless an output stall backs up into the first
// stage; each result passes through the three register stages before it leaves.
// Reset empties the pipeline and loads cell_width 8, cell_height 16.
// A stall at the output holds each full stage; empty stages ahead still fill.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module text_cell_pixel_compositor_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_character,
  input  logic [3:0]                     in_fg_index,
  input  logic [3:0]                     in_bg_index,
  input  logic [5:0]                     in_style_flags,
  input  logic [3:0]                     in_neighbor_links,
  input  logic [4:0]                     in_pixel_col,
  input  logic [5:0]                     in_pixel_row,
  input  logic [7:0]                     in_glyph_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcpc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tcpc_pkg::*;

  logic [CW_W-1:0] cell_width_r;
  logic [CH_W-1:0] cell_height_r;

  style_t          style;
  logic [3:0]      fg_sel;
  logic [3:0]      bg_sel;
  logic [7:0]      alpha;

  logic            go1, go2, go3;
  logic            v1_r, v2_r, v3_r;
  rgb_t            fg1_r, bg1_r;
  logic [7:0]      a1_r;
  logic [7:0]      a1_inv;
  logic [15:0]     sr2_r, sg2_r, sb2_r;
  logic [15:0]     sr2_nxt, sg2_nxt, sb2_nxt;
  rgb_t            out_r, out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= CW_W'(8);
      cell_height_r <= CH_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_WIDTH:  cell_width_r  <= cfg_data[CW_W-1:0];
        REG_CELL_HEIGHT: cell_height_r <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the stage after it is empty or moving on too.
  assign go3      = !v3_r || out_ready;
  assign go2      = !v2_r || go3;
  assign go1      = !v1_r || go2;
  assign in_ready = go1;

  assign style  = style_t'(in_style_flags);
  assign fg_sel = style.inverse ? in_bg_index : in_fg_index;
  assign bg_sel = style.inverse ? in_fg_index : in_bg_index;

  tcpc_coverage u_coverage (
    .character      (in_character),
    .style          (style),
    .neighbor_links (in_neighbor_links),
    .pixel_col      (in_pixel_col),
    .pixel_row      (in_pixel_row),
    .glyph_alpha    (in_glyph_alpha),
    .cell_width     (cell_width_r),
    .cell_height    (cell_height_r),
    .alpha          (alpha)
  );

  assign a1_inv = 8'd255 - a1_r;

  // Blend sums: f*a + b*(255-a), at most 255*255 so 16 bits hold them.
  always_comb begin
    sr2_nxt = {8'd0, fg1_r.red}   * {8'd0, a1_r} + {8'd0, bg1_r.red}   * {8'd0, a1_inv};
    sg2_nxt = {8'd0, fg1_r.green} * {8'd0, a1_r} + {8'd0, bg1_r.green} * {8'd0, a1_inv};
    sb2_nxt = {8'd0, fg1_r.blue}  * {8'd0, a1_r} + {8'd0, bg1_r.blue}  * {8'd0, a1_inv};
  end

  // Exact x/255 for x below 65535: (x + 1 + (x >> 8)) >> 8.
  always_comb begin
    out_nxt.red   = 8'(({1'b0, sr2_r} + 17'd1 + 17'(sr2_r[15:8])) >> 8);
    out_nxt.green = 8'(({1'b0, sg2_r} + 17'd1 + 17'(sg2_r[15:8])) >> 8);
    out_nxt.blue  = 8'(({1'b0, sb2_r} + 17'd1 + 17'(sb2_r[15:8])) >> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (go1) v1_r <= in_valid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1 && in_valid) begin
      fg1_r <= expand565(pal565(fg_sel));
      bg1_r <= expand565(pal565(bg_sel));
      a1_r  <= alpha;
    end
    if (go2 && v1_r) begin
      sr2_r <= sr2_nxt;
      sg2_r <= sg2_nxt;
      sb2_r <= sb2_nxt;
    end
    if (go3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_red   = out_r.red;
  assign out_green = out_r.green;
  assign out_blue  = out_r.blue;

  // A result can only appear after the product stage held an item.
  a_out_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without an item in the product stage");

  // A full product stage behind a stalled output keeps its item.
  a_stage2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !go3) |=> v2_r)
    else $error("product stage lost an item during a stall");

  // An empty pipeline always takes an item.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !v3_r) |-> in_ready)
    else $error("empty pipeline refused an item");

endmodule

/* rtl/core/tcpc_coverage.sv */
// ----------------------------------------------------------------------------
// tcpc_coverage
// Works out the coverage of one pixel: line-drawing strokes, borders and
// underline, falling back to the glyph alpha.
// ----------------------------------------------------------------------------
module tcpc_coverage (
  input  logic [7:0]               character,
  input  tcpc_pkg::style_t         style,
  input  logic [3:0]               neighbor_links,
  input  logic [4:0]               pixel_col,
  input  logic [5:0]               pixel_row,
  input  logic [7:0]               glyph_alpha,
  input  logic [tcpc_pkg::CW_W-1:0] cell_width,
  input  logic [tcpc_pkg::CH_W-1:0] cell_height,
  output logic [7:0]               alpha
);
  import tcpc_pkg::*;

  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_PIPE  = 8'h7C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_J     = 8'h6A;
  localparam logic [7:0] CHR_K     = 8'h6B;
  localparam logic [7:0] CHR_L     = 8'h6C;
  localparam logic [7:0] CHR_M     = 8'h6D;
  localparam logic [7:0] CHR_N     = 8'h6E;
  localparam logic [7:0] CHR_Q     = 8'h71;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_V     = 8'h76;
  localparam logic [7:0] CHR_W     = 8'h77;
  localparam logic [7:0] CHR_X     = 8'h78;

  // Direction mask bits: left, right, up, down.
  localparam logic [3:0] DIR_L = 4'b0001;
  localparam logic [3:0] DIR_R = 4'b0010;
  localparam logic [3:0] DIR_U = 4'b0100;
  localparam logic [3:0] DIR_D = 4'b1000;

  logic [3:0] base_dirs;
  logic [3:0] dirs;
  logic [4:0] mid_col;
  logic [5:0] mid_row;
  logic       on_row;
  logic       on_col;
  logic       stroke;
  logic       edge_hit;

  always_comb begin
    case (character)
      CHR_MINUS, CHR_Q: base_dirs = DIR_L | DIR_R;
      CHR_PIPE,  CHR_X: base_dirs = DIR_U | DIR_D;
      CHR_PLUS,  CHR_N: base_dirs = DIR_L | DIR_R | DIR_U | DIR_D;
      CHR_L:            base_dirs = DIR_R | DIR_D;
      CHR_K:            base_dirs = DIR_L | DIR_D;
      CHR_M:            base_dirs = DIR_R | DIR_U;
      CHR_J:            base_dirs = DIR_L | DIR_U;
      CHR_T:            base_dirs = DIR_R | DIR_U | DIR_D;
      CHR_U:            base_dirs = DIR_L | DIR_U | DIR_D;
      CHR_V:            base_dirs = DIR_L | DIR_R | DIR_U;
      CHR_W:            base_dirs = DIR_L | DIR_R | DIR_D;
      default:          base_dirs = 4'b0000;
    endcase
  end

  always_comb begin
    dirs = 4'b0000;
    if (style.line_draw) begin
      dirs = base_dirs;
      // A plus sign joins whatever neighbours reach towards it, or all four when none do.
      if (character == CHR_PLUS) begin
        dirs = (neighbor_links != 4'b0000) ? neighbor_links : 4'b1111;
      end
    end
  end

  assign mid_col = cell_width[CW_W-1:1];
  assign mid_row = cell_height[CH_W-1:1];

  assign on_row = (pixel_row == mid_row) &&
                  ((dirs[0] && dirs[1]) || (dirs[0] && pixel_col <= mid_col) ||
                   (dirs[1] && pixel_col >= mid_col));
  assign on_col = (pixel_col == mid_col) &&
                  ((dirs[2] && dirs[3]) || (dirs[2] && pixel_row <= mid_row) ||
                   (dirs[3] && pixel_row >= mid_row));
  assign stroke = on_row || on_col;

  // Last row and column are compared as index + 1, so a zero size never hits.
  assign edge_hit =
      (style.underline    && ({1'b0, pixel_row} + 7'd1 == cell_height)) ||
      (style.top_border   && (pixel_row == 6'd0)) ||
      (style.left_border  && (pixel_col == 5'd0)) ||
      (style.right_border && ({1'b0, pixel_col} + 6'd1 == cell_width));

  always_comb begin
    if (edge_hit) begin
      alpha = 8'd255;
    end else if (dirs != 4'b0000) begin
      alpha = stroke ? 8'd255 : 8'd0;
    end else begin
      alpha = glyph_alpha;
    end
  end

endmodule
